// ===== hw/rtl/spi_controller_register_model_unit_assert.svh =====
// Assertion macros for the SPI controller register model.
// Included by the top level; needs no package.
`ifndef SPI_CONTROLLER_REGISTER_MODEL_UNIT_ASSERT_SVH
`define SPI_CONTROLLER_REGISTER_MODEL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SCRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spicrm assertion failed");

// Next-cycle implication, disabled while in reset.
`define SCRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spicrm assertion failed");

`endif

// ===== hw/rtl/spicrm_pkg.sv =====
// Package for the SPI controller register model: register offsets, ID bytes, access kinds,
// field masks, status bit positions and the default FIFO depth. No dependencies.
package spicrm_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 8;

    // register offsets
    localparam logic [11:0] OFS_CR0   = 12'h000;
    localparam logic [11:0] OFS_CR1   = 12'h004;
    localparam logic [11:0] OFS_DR    = 12'h008;
    localparam logic [11:0] OFS_SR    = 12'h00C;
    localparam logic [11:0] OFS_CPSR  = 12'h010;
    localparam logic [11:0] OFS_IMSC  = 12'h014;
    localparam logic [11:0] OFS_RIS   = 12'h018;
    localparam logic [11:0] OFS_MIS   = 12'h01C;
    localparam logic [11:0] OFS_ICR   = 12'h020;
    localparam logic [11:0] OFS_DMACR = 12'h024;
    localparam logic [11:0] OFS_ID0   = 12'hFE0;
    localparam logic [11:0] OFS_ID1   = 12'hFE4;
    localparam logic [11:0] OFS_ID2   = 12'hFE8;
    localparam logic [11:0] OFS_ID3   = 12'hFEC;

    // peripheral ID bytes
    localparam logic [7:0] ID0_VAL = 8'h22;
    localparam logic [7:0] ID1_VAL = 8'h10;
    localparam logic [7:0] ID2_VAL = 8'h04;
    localparam logic [7:0] ID3_VAL = 8'h00;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // interrupt bits (RIS/MIS/IMSC/ICR)
    localparam int ST_ROR = 0;
    localparam int ST_RX  = 2;
    localparam int ST_TX  = 3;
    localparam logic [3:0] ICR_MASK = 4'b0011;

    // control1 enable bit
    localparam int CR1_SSE = 1;

endpackage

// ===== hw/rtl/spi_controller_register_model_unit.sv =====
// SPI controller register model, top level.
// Depends on spicrm_pkg and spi_controller_register_model_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): one bus access per item: kind, offset,
//   write_data and device_response. Output channel (out_valid/out_stall):
//   one result per access: read_data, irq, byte_sent, sent_byte.
//   Config channel (cfg_valid/cfg_ready/device_attached): sets whether a
//   device answers transfers. cfg_ready is always high; write it while idle.
//   An accepted item is held in the input register, processed against the
//   register state, and its result is loaded into the output register when
//   the processing stage advances. Throughput: one item per cycle while the
//   output is not stalled, set by the single processing stage that reads and
//   updates the registers and FIFO pointers.
//   The receive FIFO is a FIFO_DEPTH-entry memory; a data read pops at the
//   tail pointer and the read data lands directly in the output register.
//   Reset clears the control and status registers, the FIFO pointers and count;
//   no clearing pass is needed. When out_stall is held, the output register holds,
//   the processing stage waits, and in_stall rises once the input register is
//   occupied.
module spi_controller_register_model_unit #(
    parameter int FIFO_DEPTH = spicrm_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        device_attached,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [11:0] offset,
    input  logic [31:0] write_data,
    input  logic [7:0]  device_response,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        irq,
    output logic        byte_sent,
    output logic [7:0]  sent_byte
);

    import spicrm_pkg::*;

`include "spi_controller_register_model_unit_assert.svh"

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(FIFO_DEPTH / 2);

    // config
    logic attached_reg;

    // input register
    logic        in_valid_reg;
    logic        kind_reg;
    logic [11:0] offset_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  resp_reg;

    // register state
    logic [15:0]      ctl0_reg, ctl0_next;
    logic [3:0]       ctl1_reg, ctl1_next;
    logic [7:0]       cpsr_reg, cpsr_next;
    logic [3:0]       imsc_reg, imsc_next;
    logic [1:0]       dmacr_reg, dmacr_next;
    logic [3:0]       ris_reg, ris_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // receive FIFO storage
    logic [7:0] rx_mem [FIFO_DEPTH];
    logic [7:0] rx_data_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] rdata_reg, rdata_next;
    logic        pop_hit_reg, pop_hit_next;
    logic        irq_reg, irq_next;
    logic        sent_reg, sent_next;
    logic [7:0]  sbyte_reg, sbyte_next;

    logic       adv;
    logic       in_take;
    logic       push_we;
    logic [7:0] push_byte;

    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !adv;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        logic is_wr;
        logic status_upd;
        logic do_push;
        is_wr      = (kind_reg == KIND_WRITE);
        status_upd = is_wr;
        do_push    = 1'b0;

        ctl0_next    = ctl0_reg;
        ctl1_next    = ctl1_reg;
        cpsr_next    = cpsr_reg;
        imsc_next    = imsc_reg;
        dmacr_next   = dmacr_reg;
        ris_next     = ris_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        rdata_next   = '0;
        pop_hit_next = 1'b0;
        sent_next    = 1'b0;
        sbyte_next   = '0;
        push_we      = 1'b0;
        push_byte    = attached_reg ? resp_reg : 8'h00;

        if (!is_wr)
        begin
            case (offset_reg)
                OFS_CR0:   rdata_next = 32'(ctl0_reg);
                OFS_CR1:   rdata_next = 32'(ctl1_reg);
                OFS_DR:
                begin
                    status_upd = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        pop_hit_next = 1'b1;
                        tail_next    = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                        cnt_next     = cnt_reg - 1'b1;
                    end
                end
                OFS_SR:    rdata_next = {28'd0, (cnt_reg == CNT_FULL), (cnt_reg != '0),
                                         2'b11};
                OFS_CPSR:  rdata_next = 32'(cpsr_reg);
                OFS_IMSC:  rdata_next = 32'(imsc_reg);
                OFS_RIS:   rdata_next = 32'(ris_reg);
                OFS_MIS:   rdata_next = 32'(ris_reg & imsc_reg);
                OFS_DMACR: rdata_next = 32'(dmacr_reg);
                OFS_ID0:   rdata_next = 32'(ID0_VAL);
                OFS_ID1:   rdata_next = 32'(ID1_VAL);
                OFS_ID2:   rdata_next = 32'(ID2_VAL);
                OFS_ID3:   rdata_next = 32'(ID3_VAL);
                default:   rdata_next = '0;
            endcase
        end
        else
        begin
            case (offset_reg)
                OFS_CR0:   ctl0_next  = wdata_reg[15:0];
                OFS_CR1:   ctl1_next  = wdata_reg[3:0];
                OFS_DR:
                begin
                    if (ctl1_reg[CR1_SSE])
                    begin
                        do_push    = 1'b1;
                        sent_next  = attached_reg;
                        sbyte_next = attached_reg ? wdata_reg[7:0] : 8'h00;
                    end
                end
                OFS_CPSR:  cpsr_next  = wdata_reg[7:0];
                OFS_IMSC:  imsc_next  = wdata_reg[3:0];
                OFS_ICR:   ris_next   = ris_reg & ~(wdata_reg[3:0] & ICR_MASK);
                OFS_DMACR: dmacr_next = wdata_reg[1:0];
                default:   ;
            endcase
        end

        // full FIFO drops the reply and flags overrun
        if (do_push)
        begin
            if (cnt_reg == CNT_FULL)
            begin
                ris_next[ST_ROR] = 1'b1;
            end
            else
            begin
                push_we   = 1'b1;
                head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
        end

        if (status_upd)
        begin
            ris_next[ST_TX] = 1'b1;
            ris_next[ST_RX] = (cnt_next >= CNT_HALF);
        end

        irq_next = |(ris_next & imsc_next);
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attached_reg <= device_attached;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind;
            offset_reg <= offset;
            wdata_reg  <= write_data;
            resp_reg   <= device_response;
        end
    end

    // register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg  <= '0;
            ctl1_reg  <= '0;
            cpsr_reg  <= '0;
            imsc_reg  <= '0;
            dmacr_reg <= '0;
            ris_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (adv)
        begin
            ctl0_reg  <= ctl0_next;
            ctl1_reg  <= ctl1_next;
            cpsr_reg  <= cpsr_next;
            imsc_reg  <= imsc_next;
            dmacr_reg <= dmacr_next;
            ris_reg   <= ris_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
        end
    end

    // FIFO write port
    always_ff @(posedge clk)
    begin
        if (adv && push_we)
        begin
            rx_mem[head_reg] <= push_byte;
        end
    end

    // FIFO read port, registered straight into the result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_data_reg <= rx_mem[tail_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata_reg   <= rdata_next;
            pop_hit_reg <= pop_hit_next;
            irq_reg     <= irq_next;
            sent_reg    <= sent_next;
            sbyte_reg   <= sbyte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = pop_hit_reg ? {24'd0, rx_data_reg} : rdata_reg;
    assign irq       = irq_reg;
    assign byte_sent = sent_reg;
    assign sent_byte = sbyte_reg;

    // assertions
    `SCRM_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_FULL)
    `SCRM_ASSERT_IMPL(a_sent_needs_dev, clk, rst_n, out_valid_reg && sent_reg, attached_reg)
    `SCRM_ASSERT_NEXT(a_ror_sticky, clk, rst_n,
        ris_reg[ST_ROR] && !(adv && kind_reg && (offset_reg == OFS_ICR) && wdata_reg[ST_ROR]),
        ris_reg[ST_ROR])
    `SCRM_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, adv && pop_hit_next, cnt_reg != '0)

endmodule

// ===== sim/spi_controller_register_model_unit_tb.sv =====
// Testbench for spi_controller_register_model_unit: directed register and FIFO cases, then
// random bus traffic, each result checked against an in-bench register model.
// Depends on spicrm_pkg and the RTL top level only.
module spi_controller_register_model_unit_tb;
    import spicrm_pkg::*;

    localparam int RX_DEPTH = DEFAULT_FIFO_DEPTH;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS = 10;

    // SR bit positions
    localparam int SR_TFE = 0;
    localparam int SR_TNF = 1;
    localparam int SR_RNE = 2;
    localparam int SR_RFF = 3;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        byte_sent;
        logic [7:0]  sent_byte;
    } bus_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        device_attached;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [7:0]  device_response;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic        irq;
    logic        byte_sent;
    logic [7:0]  sent_byte;

    // register model state
    logic        model_attached;
    logic [15:0] model_cr0;
    logic [3:0]  model_cr1;
    logic [7:0]  model_cpsr;
    logic [3:0]  model_imsc;
    logic [1:0]  model_dmacr;
    logic [3:0]  model_ris;
    logic [7:0]  rx_bytes[$];

    bus_reply_t  replies_due[$];
    int          error_count;
    int          idle_cycles;
    bit          idle_on;

    spi_controller_register_model_unit #(
        .FIFO_DEPTH(RX_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .device_attached(device_attached),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .offset(offset),
        .write_data(write_data),
        .device_response(device_response),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .irq(irq),
        .byte_sent(byte_sent),
        .sent_byte(sent_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void refresh_status();
        model_ris[ST_TX] = 1'b1;
        model_ris[ST_RX] = (rx_bytes.size() >= RX_DEPTH / 2);
    endfunction

    function automatic void push_reply(input logic [7:0] b);
        if (rx_bytes.size() >= RX_DEPTH)
            model_ris[ST_ROR] = 1'b1;
        else
            rx_bytes.push_back(b);
    endfunction

    function automatic bus_reply_t predict_bus_access(input logic k, input logic [11:0] ofs,
                                                      input logic [31:0] wd,
                                                      input logic [7:0] resp);
        bus_reply_t r;
        r = '0;
        if (k == KIND_READ)
        begin
            case (ofs)
                OFS_CR0:   r.read_data = 32'(model_cr0);
                OFS_CR1:   r.read_data = 32'(model_cr1);
                OFS_DR:
                begin
                    if (rx_bytes.size() > 0)
                        r.read_data = 32'(rx_bytes.pop_front());
                    refresh_status();
                end
                OFS_SR:
                begin
                    r.read_data[SR_TFE] = 1'b1;
                    r.read_data[SR_TNF] = 1'b1;
                    r.read_data[SR_RNE] = (rx_bytes.size() > 0);
                    r.read_data[SR_RFF] = (rx_bytes.size() >= RX_DEPTH);
                end
                OFS_CPSR:  r.read_data = 32'(model_cpsr);
                OFS_IMSC:  r.read_data = 32'(model_imsc);
                OFS_RIS:   r.read_data = 32'(model_ris);
                OFS_MIS:   r.read_data = 32'(model_ris & model_imsc);
                OFS_DMACR: r.read_data = 32'(model_dmacr);
                OFS_ID0:   r.read_data = 32'(ID0_VAL);
                OFS_ID1:   r.read_data = 32'(ID1_VAL);
                OFS_ID2:   r.read_data = 32'(ID2_VAL);
                OFS_ID3:   r.read_data = 32'(ID3_VAL);
                default:   r.read_data = '0;
            endcase
        end
        else
        begin
            case (ofs)
                OFS_CR0:   model_cr0 = wd[15:0];
                OFS_CR1:   model_cr1 = wd[3:0];
                OFS_DR:
                begin
                    if (model_cr1[CR1_SSE])
                    begin
                        if (model_attached)
                        begin
                            r.byte_sent = 1'b1;
                            r.sent_byte = wd[7:0];
                            push_reply(resp);
                        end
                        else
                            push_reply(8'h00);
                    end
                end
                OFS_CPSR:  model_cpsr = wd[7:0];
                OFS_IMSC:  model_imsc = wd[3:0];
                OFS_ICR:   model_ris = model_ris & ~(wd[3:0] & ICR_MASK);
                OFS_DMACR: model_dmacr = wd[1:0];
                default:   ;
            endcase
            refresh_status();
        end
        r.irq = |(model_ris & model_imsc);
        return r;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Predicts on every accepted access, checks every accepted result, runs the watchdog.
    always @(posedge clk)
    begin : bus_monitor
        bus_reply_t want;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (replies_due.size() == 0)
                    note_error($sformatf("unexpected result read_data=%h", read_data));
                else
                begin
                    want = replies_due.pop_front();
                    if (read_data !== want.read_data)
                        note_error($sformatf("read_data exp %h got %h",
                                             want.read_data, read_data));
                    if (irq !== want.irq)
                        note_error($sformatf("irq exp %b got %b", want.irq, irq));
                    if (byte_sent !== want.byte_sent)
                        note_error($sformatf("byte_sent exp %b got %b",
                                             want.byte_sent, byte_sent));
                    if (sent_byte !== want.sent_byte)
                        note_error($sformatf("sent_byte exp %h got %h",
                                             want.sent_byte, sent_byte));
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                replies_due.push_back(predict_bus_access(kind, offset, write_data,
                                                         device_response));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("spi_controller_register_model_unit_tb: errors");
                $finish;
            end
        end
    end

    // Receiver stalls in random bursts while idling is on.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Entered after a rising edge; returns at the rising edge that accepts the item.
    task automatic send_access(input logic k, input logic [11:0] ofs, input logic [31:0] wd,
                               input logic [7:0] resp);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        kind            <= k;
        offset          <= ofs;
        write_data      <= wd;
        device_response <= resp;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_device_attached(input logic v);
        wait_for_results();
        @(negedge clk);
        cfg_valid       <= 1'b1;
        device_attached <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_attached = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_access(KIND_READ, OFS_RIS, 32'hFFFF_FFFF, 8'hFF);   // TX not yet set
        send_access(KIND_READ, OFS_DR, '0, '0);                  // pop of an empty FIFO
        send_access(KIND_READ, OFS_SR, '0, '0);
        send_access(KIND_READ, OFS_ID0, '0, '0);
        send_access(KIND_READ, OFS_ID3, '0, '0);
        send_access(KIND_READ, 12'hFFF, '0, '0);
    endtask

    task automatic test_register_masks();
        send_access(KIND_WRITE, OFS_CR0, 32'hFFFF_FFFF, 8'h00);
        send_access(KIND_READ, OFS_CR0, '0, '0);
        send_access(KIND_WRITE, OFS_CPSR, 32'hFFFF_FFFF, 8'h00);
        send_access(KIND_WRITE, OFS_DMACR, 32'hFFFF_FFFF, 8'h00);
        send_access(KIND_WRITE, OFS_IMSC, 32'hFFFF_FFFF, 8'h00);
        send_access(KIND_WRITE, OFS_SR, 32'hFFFF_FFFF, 8'h00);   // read-only
        send_access(KIND_READ, OFS_MIS, '0, '0);
        send_access(KIND_WRITE, 12'h002, 32'hFFFF_FFFF, 8'h00);  // misaligned
    endtask

    task automatic test_detached_transfer();
        set_device_attached(1'b0);
        send_access(KIND_WRITE, OFS_CR1, 32'h0000_000F, 8'h00);
        send_access(KIND_WRITE, OFS_DR, 32'hFFFF_FFFF, 8'hFF);   // zero reply, nothing sent
        send_access(KIND_READ, OFS_DR, '0, '0);
    endtask

    task automatic test_disabled_write();
        send_access(KIND_WRITE, OFS_CR1, 32'hFFFF_FFF0, 8'h00);
        send_access(KIND_WRITE, OFS_DR, 32'h0000_00A5, 8'h5A);
    endtask

    task automatic test_overrun_and_clear();
        set_device_attached(1'b1);
        send_access(KIND_WRITE, OFS_CR1, 32'h0000_0002, 8'h00);
        for (int i = 0; i <= RX_DEPTH; i++)
            send_access(KIND_WRITE, OFS_DR, 32'(i * 32'h1F1F_1F1F),
                        (i == 0) ? 8'h00 : 8'hFF - 8'(i));
        send_access(KIND_READ, OFS_SR, '0, '0);
        send_access(KIND_READ, OFS_RIS, '0, '0);
        send_access(KIND_WRITE, OFS_ICR, 32'hFFFF_FFFF, 8'h00);
        send_access(KIND_READ, OFS_DR, '0, '0);
    endtask

    // push_pct sets how often data is written, so some phases fill the FIFO and some drain it.
    task automatic run_bus_traffic(input int count, input int push_pct);
        int          pick;
        logic [31:0] wd;
        for (int i = 0; i < count; i++)
        begin
            wd   = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                send_access(KIND_WRITE, OFS_DR, wd, 8'($urandom));
            else if (pick < 62)
                send_access(KIND_READ, OFS_DR, wd, 8'($urandom));
            else if (pick < 68)
            begin
                wd[CR1_SSE] = ($urandom_range(0, 9) != 0);
                send_access(KIND_WRITE, OFS_CR1, wd, 8'($urandom));
            end
            else if (pick < 74)
                send_access(KIND_WRITE, ($urandom_range(0, 1) != 0) ? OFS_ICR : OFS_IMSC,
                            wd, 8'($urandom));
            else if (pick < 90)
                send_access(1'($urandom), 12'($urandom_range(0, 9) * 4), wd, 8'($urandom));
            else if (pick < 95)
                send_access(1'($urandom), OFS_ID0 + 12'($urandom_range(0, 3) * 4), wd,
                            8'($urandom));
            else
                send_access(1'($urandom), 12'($urandom), wd, 8'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0, 2, 3: set_device_attached(1'b1);
                1, 4:    set_device_attached(1'b0);
                default: set_device_attached(1'($urandom));
            endcase
            if (p == 5)
                idle_on = 1'b0;
            run_bus_traffic(265, $urandom_range(20, 45));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        device_attached = 1'b0;
        in_valid        = 1'b0;
        kind            = KIND_READ;
        offset          = '0;
        write_data      = '0;
        device_response = '0;
        error_count     = 0;
        idle_cycles     = 0;
        idle_on         = 1'b1;
        model_attached  = 1'b0;
        model_cr0       = '0;
        model_cr1       = '0;
        model_cpsr      = '0;
        model_imsc      = '0;
        model_dmacr     = '0;
        model_ris       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_masks();
        test_detached_transfer();
        test_disabled_write();
        test_overrun_and_clear();
        test_random_traffic();

        wait_for_results();
        if (replies_due.size() != 0)
            note_error($sformatf("%0d results never arrived", replies_due.size()));
        if (error_count == 0)
            $display("spi_controller_register_model_unit_tb: clean");
        else
            $display("spi_controller_register_model_unit_tb: errors");
        $finish;
    end

endmodule
